// ===== rtl/delimited_frame_receiver_macros.svh =====
// Assertion helpers; the including scope provides clk_i and rst_ni.
`ifndef DELIMITED_FRAME_RECEIVER_MACROS_SVH
`define DELIMITED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication.
`define DFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dfr: same-cycle check failed");

// Next-cycle implication.
`define DFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dfr: next-cycle check failed");

`endif

// ===== rtl/dfr_pkg.sv =====
`default_nettype none

package dfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 2'd1;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd60;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd62;

  typedef struct packed {
    logic take;     // input transfer this cycle
    logic rd_en;    // load read register from store
    logic advance;  // step read pointer
  } dfr_cmd_t;

  typedef struct packed {
    logic frame_done;  // accepted byte completes a frame
    logic last;        // read pointer on final byte
  } dfr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/dfr_ctrl.sv =====
`default_nettype none

module dfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  dfr_pkg::dfr_sts_t sts_i,
  output dfr_pkg::dfr_cmd_t cmd_o
);
  import dfr_pkg::*;

  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_SHOW   = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    cmd_o.take    = 1'b0;
    cmd_o.rd_en   = 1'b0;
    cmd_o.advance = 1'b0;
    case (state_q)
      ST_ACCEPT: begin
        s_tready   = 1'b1;
        cmd_o.take = s_tvalid;
        if (s_tvalid && sts_i.frame_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SHOW;
      end
      ST_SHOW: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (sts_i.last) begin
            state_d = ST_ACCEPT;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCEPT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dfr_dpath.sv =====
`default_nettype none

module dfr_dpath #(
  parameter int FRAME_CAPACITY = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [dfr_pkg::BYTE_W-1:0]         rx_byte_i,
  input  logic                               cfg_we_i,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dfr_pkg::BYTE_W-1:0]         cfg_data_i,
  input  dfr_pkg::dfr_cmd_t                  cmd_i,
  output dfr_pkg::dfr_sts_t                  sts_o,
  output logic [dfr_pkg::BYTE_W-1:0]         frame_byte_o
);
  import dfr_pkg::*;

  localparam int IDX_W = (FRAME_CAPACITY > 2) ? $clog2(FRAME_CAPACITY) : 1;
  localparam int CNT_W = IDX_W + 1;

  logic [BYTE_W-1:0] start_byte_q, end_byte_q;
  logic [IDX_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]  last_idx_q, last_idx_d;
  logic [BYTE_W-1:0] mem [FRAME_CAPACITY];
  logic [BYTE_W-1:0] rd_data_q;

  logic              store_byte;
  logic [CNT_W-1:0]  count_inc;
  logic              overflow;

  assign store_byte = (rx_byte_i != '0) &&
                      ((count_q != '0) || (rx_byte_i == start_byte_q));
  assign count_inc  = {1'b0, count_q} + CNT_W'(1);
  assign overflow   = (count_inc == CNT_W'(FRAME_CAPACITY));

  assign sts_o.frame_done = store_byte && !overflow && (rx_byte_i == end_byte_q);
  assign sts_o.last       = (rd_idx_q == last_idx_q);
  assign frame_byte_o     = rd_data_q;

  always_comb begin
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    last_idx_d = last_idx_q;
    if (cmd_i.take && store_byte) begin
      if (overflow || (rx_byte_i == end_byte_q)) begin
        count_d = '0;
      end else begin
        count_d = count_inc[IDX_W-1:0];
      end
      if (sts_o.frame_done) begin
        rd_idx_d   = '0;
        last_idx_d = count_q;
      end
    end
    if (cmd_i.advance) begin
      rd_idx_d = rd_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      end_byte_q   <= END_BYTE_RST;
      count_q      <= '0;
      rd_idx_q     <= '0;
      last_idx_q   <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == REG_START_BYTE)) begin
        start_byte_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == REG_END_BYTE)) begin
        end_byte_q <= cfg_data_i;
      end
      count_q    <= count_d;
      rd_idx_q   <= rd_idx_d;
      last_idx_q <= last_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && store_byte) begin
      mem[count_q] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/delimited_frame_receiver.sv =====
// Channel  | Direction | Signals                         | Contents
// s        | in        | s_tvalid/s_tready/s_tdata       | rx_byte
// m        | out       | m_tvalid/m_tready/m_tdata/tlast | frame_byte, frame_last
// cfg      | in        | cfg_valid_i/cfg_ready_o/...     | 0 start_byte, 1 end_byte
//
// A received byte is taken whenever no frame is being sent.
// A completed frame is sent byte by byte: each byte is read from the store,
// then transferred on m, and held there while m_tready is low.
// While a frame is sent, s_tready stays low; cfg is always ready.
// Reset: start_byte 60, end_byte 62, empty frame; the store itself is not cleared.
`default_nettype none

module delimited_frame_receiver #(
  parameter int FRAME_CAPACITY = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] frame_byte
  output logic                           m_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dfr_pkg::BYTE_W-1:0]     cfg_data_i
);
  import dfr_pkg::*;

  dfr_cmd_t cmd;
  dfr_sts_t sts;

  assign cfg_ready_o = 1'b1;
  assign m_tlast     = sts.last;

  dfr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  dfr_dpath #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (s_tdata),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .frame_byte_o (m_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/dfr_checker.sv =====
`default_nettype none
`include "delimited_frame_receiver_macros.svh"

module dfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  `DFR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  `DFR_ASSERT_IMPL(a_no_overlap, m_tvalid, !s_tready)
  `DFR_ASSERT_NEXT(a_resume_after_last, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid)
  `DFR_ASSERT_NEXT(a_zero_ignored, s_tvalid && s_tready && (s_tdata == 8'd0), s_tready && !m_tvalid)

endmodule

bind delimited_frame_receiver dfr_checker u_dfr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/sv/delimited_frame_receiver_test.sv =====
`timescale 1ns / 100ps

module delimited_frame_receiver_test;
  import dfr_pkg::*;

  localparam int FRAME_CAP   = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYC  = 8;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata = '0;     // [7:0] rx_byte
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [BYTE_W-1:0]    m_tdata;          // [7:0] frame_byte
  logic                 m_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [BYTE_W-1:0]    cfg_data_i = '0;

  delimited_frame_receiver #(
    .FRAME_CAPACITY(FRAME_CAP)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [BYTE_W-1:0] rx_pending_q[$];
  frame_beat_t       frame_beats_q[$];
  bit                no_idle = 1'b0;
  bit                rx_xfer_seen = 1'b0;
  bit                tx_xfer_seen = 1'b0;
  int                rx_gap = 0;
  int                tx_stall = 0;
  int                err_cnt = 0;
  int                cycle_cnt = 0;

  // frame assembly state
  logic [BYTE_W-1:0] frame_mem [FRAME_CAP];
  int                open_len;
  logic [BYTE_W-1:0] start_val;
  logic [BYTE_W-1:0] end_val;

  // generator's view of the delimiters
  logic [BYTE_W-1:0] gen_start = START_BYTE_RST;
  logic [BYTE_W-1:0] gen_end = END_BYTE_RST;

  task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b);
    frame_beat_t beat;
    int          i;
    if (b == '0) return;
    if (open_len == 0 && b != start_val) return;
    frame_mem[open_len] = b;
    open_len++;
    if (open_len >= FRAME_CAP) begin
      open_len = 0;
      return;
    end
    if (b != end_val) return;
    for (i = 0; i < open_len; i++) begin
      beat.data = frame_mem[i];
      beat.last = (i == open_len - 1);
      frame_beats_q.push_back(beat);
    end
    open_len = 0;
  endtask

  // rx side
  always @(negedge clk_i) begin
    if (s_tvalid && !rx_xfer_seen) begin
    end else if (rx_gap > 0) begin
      s_tvalid <= 1'b0;
      rx_gap--;
    end else if (rx_pending_q.size() != 0) begin
      s_tdata  <= rx_pending_q.pop_front();
      s_tvalid <= 1'b1;
      rx_gap = no_idle ? 0 : $urandom_range(0, 8);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // tx side backpressure
  always @(negedge clk_i) begin
    if (tx_xfer_seen) tx_stall = no_idle ? 0 : $urandom_range(0, 8);
    if (tx_stall > 0) begin
      m_tready <= 1'b0;
      tx_stall--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    frame_beat_t want;
    if (!rst_ni) begin
      rx_xfer_seen <= 1'b0;
      tx_xfer_seen <= 1'b0;
      open_len = 0;
      start_val = START_BYTE_RST;
      end_val = END_BYTE_RST;
    end else begin
      rx_xfer_seen <= s_tvalid && s_tready;
      tx_xfer_seen <= m_tvalid && m_tready;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_START_BYTE: start_val = cfg_data_i;
          REG_END_BYTE:   end_val = cfg_data_i;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (frame_beats_q.size() == 0) begin
          $display("%0t: unexpected transfer, actual byte %02h last %0b",
                   $time, m_tdata, m_tlast);
          err_cnt++;
        end else begin
          want = frame_beats_q.pop_front();
          if (m_tdata !== want.data) begin
            $display("%0t: frame byte expected %02h actual %02h",
                     $time, want.data, m_tdata);
            err_cnt++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: tlast expected %0b actual %0b", $time, want.last, m_tlast);
            err_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) absorb_rx_byte(s_tdata);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_START_BYTE) gen_start = val;
    else if (idx == REG_END_BYTE) gen_end = val;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (rx_pending_q.size() != 0 || s_tvalid || frame_beats_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic push_bytes(input logic [BYTE_W-1:0] b[$]);
    foreach (b[i]) rx_pending_q.push_back(b[i]);
  endtask

  // plain: body holds no zero, start or end byte, so its length is exact
  task automatic queue_frame(input int body_len, input bit plain, input bit closed);
    logic [BYTE_W-1:0] b;
    int                i;
    rx_pending_q.push_back(gen_start);
    for (i = 0; i < body_len; i++) begin
      if (!plain && $urandom_range(0, 9) == 0) begin
        b = '0;
      end else if (!plain && $urandom_range(0, 7) == 0) begin
        b = gen_start;
      end else begin
        do b = BYTE_W'($urandom_range(1, 255));
        while (b == gen_end || (plain && b == gen_start));
      end
      rx_pending_q.push_back(b);
    end
    if (closed) rx_pending_q.push_back(gen_end);
  endtask

  task automatic queue_traffic(input int n_items);
    logic [BYTE_W-1:0] b;
    int                sent;
    int                kind;
    int                len;
    int                i;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        len = $urandom_range(1, 3);
        for (i = 0; i < len; i++) begin
          b = BYTE_W'($urandom_range(0, 255));
          if (b == gen_start) b = '0;
          rx_pending_q.push_back(b);
        end
      end else if (kind == 3) begin
        queue_frame(FRAME_CAP - 3, 1'b1, 1'b1);
        sent += FRAME_CAP - 1;
      end else if (kind == 4) begin
        queue_frame(FRAME_CAP - 2, 1'b1, 1'b1);
        sent += FRAME_CAP;
      end else if (kind == 5) begin
        len = $urandom_range(0, 5);
        queue_frame(len, 1'b0, 1'b0);
        sent += len + 1;
      end else begin
        len = $urandom_range(0, 6);
        queue_frame(len, 1'b0, 1'b1);
        sent += len + 2;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset delimiters '<' and '>'
    push_bytes('{8'h3E, 8'h00, 8'h3C, 8'h41, 8'h3E});
    push_bytes('{8'h3C, 8'h00, 8'h3C, 8'hFF, 8'h01, 8'h3E});
    push_bytes('{8'h80, 8'h3C, 8'h3E});
    wait_drained();

    // same byte opens and closes
    write_reg(REG_START_BYTE, 8'h5A);
    write_reg(REG_END_BYTE, 8'h5A);
    push_bytes('{8'h5A, 8'h11, 8'h5A, 8'h00});
    wait_drained();

    // zero start byte: nothing can open
    write_reg(REG_START_BYTE, 8'h00);
    write_reg(REG_END_BYTE, 8'h10);
    push_bytes('{8'h10, 8'hAB, 8'h00});
    wait_drained();

    // zero end byte: frame can only overflow
    write_reg(REG_START_BYTE, 8'h33);
    write_reg(REG_END_BYTE, 8'h00);
    queue_frame(FRAME_CAP - 1, 1'b1, 1'b0);
    wait_drained();

    write_reg(REG_START_BYTE, 8'h01);
    write_reg(REG_END_BYTE, 8'hFF);
    write_reg(REG_SPARE_2, 8'hFF);
    write_reg(REG_SPARE_3, 8'h00);
    queue_frame(FRAME_CAP - 3, 1'b1, 1'b1);
    queue_frame(FRAME_CAP - 2, 1'b1, 1'b1);
    queue_traffic(4);
    wait_drained();

    write_reg(REG_START_BYTE, 8'hFF);
    write_reg(REG_END_BYTE, 8'h01);
    no_idle = 1'b1;
    queue_traffic(4);
    wait_drained();

    repeat (3) begin
      write_reg(REG_START_BYTE, BYTE_W'($urandom_range(1, 255)));
      write_reg(REG_END_BYTE, BYTE_W'($urandom_range(1, 255)));
      no_idle = ($urandom_range(0, 3) == 0);
      queue_traffic(4);
      wait_drained();
    end

    repeat (SETTLE_CYC) @(posedge clk_i);
    if (frame_beats_q.size() != 0) begin
      $display("%0t: %0d frame bytes never arrived", $time, frame_beats_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
